[sv/sti_pkg.sv]
// Package for the sorted table linear interpolator.
// Holds word types, field widths, action and status codes.
// No dependencies.
package sti_pkg;

  localparam int VALUE_FRAC_BITS = 8;
  localparam int VALUE_W         = 12 + VALUE_FRAC_BITS;
  localparam int TIME_W          = 40;
  localparam int DIFF_W          = TIME_W + 1;
  localparam int COUNT_OUT_W     = 11;
  localparam int KP_SHIFT        = 3;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_DATA = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ORDER   = 2'd3;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [TIME_W-1:0] time_s;
    logic [VALUE_W-1:0]       flux_in;
    logic [VALUE_W-1:0]       flux_center_in;
    logic [VALUE_W-1:0]       ap_in;
    logic [VALUE_W-1:0]       kp_sum_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [VALUE_W-1:0]     flux_out;
    logic [VALUE_W-1:0]     flux_center_out;
    logic [VALUE_W-1:0]     ap_out;
    logic [VALUE_W-1:0]     kp_out;
    logic                   interpolated;
    logic                   extrapolated;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_word_t;

  // One stored sample
  typedef struct packed {
    logic signed [TIME_W-1:0] time_s;
    logic [VALUE_W-1:0]       flux;
    logic [VALUE_W-1:0]       flux_center;
    logic [VALUE_W-1:0]       ap;
    logic [VALUE_W-1:0]       kp;
  } entry_t;

endpackage

[sv/sti_mem.sv]
// Sample memory: one write port, one read port, registered read data.
// Depends on sti_pkg for the entry type.
module sti_mem import sti_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // Write the appended sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry a cycle
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/sti_div.sv]
// Restoring divider for alpha: one quotient bit a cycle.
// Depends on sti_pkg for the difference width.
module sti_div import sti_pkg::*; #(
  parameter int ALPHA_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [DIFF_W-1:0]     num,
  input  logic [DIFF_W-1:0]     den,
  output logic                  done,
  output logic [ALPHA_BITS-1:0] alpha
);

  localparam int CNT_W = $clog2(ALPHA_BITS + 1);

  logic [DIFF_W-1:0]     rem_r, rem_nxt;
  logic [DIFF_W-1:0]     den_r, den_nxt;
  logic [ALPHA_BITS-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  run_r, run_nxt;
  logic                  done_r, done_nxt;
  logic [DIFF_W:0]       shifted;

  // Shift, compare and subtract
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, 1'b0};
    if (go) begin
      rem_nxt = num;
      den_nxt = den;
      q_nxt   = '0;
      cnt_nxt = CNT_W'(ALPHA_BITS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = DIFF_W'(shifted - {1'b0, den_r});
        q_nxt   = {q_r[ALPHA_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIFF_W-1:0];
        q_nxt   = {q_r[ALPHA_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done  = done_r;
  assign alpha = q_r;

endmodule

[sv/sorted_table_linear_interpolator_top.sv]
// Top level of the sorted table linear interpolator.
// Depends on sti_pkg, sti_mem and sti_div.
//
// Usage: a word is taken on in_data when start is high and busy is low.
// Every word gives exactly one result word on out_data, shown for one
// cycle with out_strobe high; the receiver cannot hold it off.
// Clear and append finish without leaving idle: the result follows on the next
// cycle and busy stays low, so such words may arrive back to back.
// Appends write the sample memory at the fill count; out-of-order and
// full-table appends are refused with a status.
// A query walks the sample memory with registered reads: it checks the first
// and then the last entry, each binary search probe sets the address, reads
// and compares, one more step closes the search, and the two bracketing
// entries are then read. The divider then forms alpha, and the four blends
// share one multiplier. A search makes at most ceil(log2(count - 1)) probes;
// busy stays high until the last step and the result word follows on the
// next cycle. An end hit answers from the first or last entry without a
// search.
// Synchronous reset empties the table; the memory is not cleared, only
// entries below the fill count are ever read.
module sorted_table_linear_interpolator_top import sti_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int ALPHA_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_strobe,
  output out_word_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = VALUE_W + ALPHA_BITS + 2;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_W0   = 15'b000000000000010,
    S_C0   = 15'b000000000000100,
    S_WL   = 15'b000000000001000,
    S_CL   = 15'b000000000010000,
    S_SRCH = 15'b000000000100000,
    S_WM   = 15'b000000001000000,
    S_CM   = 15'b000000010000000,
    S_WLO  = 15'b000000100000000,
    S_CLO  = 15'b000001000000000,
    S_WHI  = 15'b000010000000000,
    S_CHI  = 15'b000100000000000,
    S_DIV  = 15'b001000000000000,
    S_MUL  = 15'b010000000000000,
    S_ACC  = 15'b100000000000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [TIME_W-1:0] last_time_r, last_time_nxt;
  logic signed [TIME_W-1:0] t_r, t_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic [AW-1:0]            lo_r, lo_nxt;
  logic [AW-1:0]            hi_r, hi_nxt;
  entry_t                   lo_e_r, lo_e_nxt;
  entry_t                   hi_e_r, hi_e_nxt;
  logic [1:0]               k_r, k_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic [VALUE_W-1:0]       vals_r [4];
  logic [VALUE_W-1:0]       vals_nxt [4];
  logic                     out_strobe_r, out_strobe_nxt;
  out_word_t                out_data_r, out_data_nxt;

  logic                     we;
  entry_t                   wdata;
  entry_t                   rdata;
  logic                     div_go;
  logic                     div_done;
  logic [ALPHA_BITS-1:0]    alpha;
  logic [DIFF_W-1:0]        num;
  logic [DIFF_W-1:0]        den;
  logic [AW-1:0]            mid;
  logic [AW-1:0]            last_idx;
  logic [VALUE_W-1:0]       lo_v;
  logic [VALUE_W-1:0]       hi_v;
  logic signed [VALUE_W:0]  dv;
  logic signed [PW-1:0]     base_s;
  logic signed [PW-1:0]     sum_s;

  function automatic logic [VALUE_W-1:0] field_of(entry_t e, logic [1:0] k);
    logic [VALUE_W-1:0] v;
    unique case (k)
      2'd0:    v = e.flux;
      2'd1:    v = e.flux_center;
      2'd2:    v = e.ap;
      default: v = e.kp;
    endcase
    return v;
  endfunction

  function automatic out_word_t sample_word(entry_t e, logic ext, logic [CW-1:0] c);
    out_word_t w;
    w                 = '0;
    w.status          = ST_OK;
    w.flux_out        = e.flux;
    w.flux_center_out = e.flux_center;
    w.ap_out          = e.ap;
    w.kp_out          = e.kp;
    w.extrapolated    = ext;
    w.entry_count     = COUNT_OUT_W'(c);
    return w;
  endfunction

  sti_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[AW-1:0]),
    .wdata (wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  sti_div #(.ALPHA_BITS(ALPHA_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (div_go),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .alpha (alpha)
  );

  // Sample as it goes into the memory
  always_comb begin
    wdata.time_s      = in_data.time_s;
    wdata.flux        = in_data.flux_in;
    wdata.flux_center = in_data.flux_center_in;
    wdata.ap          = in_data.ap_in;
    wdata.kp          = in_data.kp_sum_in >> KP_SHIFT;
  end

  // Elapsed and full interval of the bracketing pair
  assign num = DIFF_W'($signed({t_r[TIME_W-1], t_r}) -
                       $signed({lo_e_r.time_s[TIME_W-1], lo_e_r.time_s}));
  assign den = DIFF_W'($signed({hi_e_r.time_s[TIME_W-1], hi_e_r.time_s}) -
                       $signed({lo_e_r.time_s[TIME_W-1], lo_e_r.time_s}));

  assign mid      = lo_r + ((hi_r - lo_r) >> 1);
  assign last_idx = AW'(count_r - 1'b1);

  // Blend datapath: lo * 2^A + alpha * (hi - lo), then drop the fraction
  assign lo_v   = field_of(lo_e_r, k_r);
  assign hi_v   = field_of(hi_e_r, k_r);
  assign dv     = $signed({1'b0, hi_v}) - $signed({1'b0, lo_v});
  assign base_s = $signed({2'b00, lo_v, {ALPHA_BITS{1'b0}}});
  assign sum_s  = base_s + prod_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_time_nxt  = last_time_r;
    t_nxt          = t_r;
    addr_nxt       = addr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    lo_e_nxt       = lo_e_r;
    hi_e_nxt       = hi_e_r;
    k_nxt          = k_r;
    prod_nxt       = prod_r;
    vals_nxt       = vals_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    we             = 1'b0;
    div_go         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          t_nxt        = in_data.time_s;
          out_data_nxt = '0;
          priority if (in_data.action == ACT_CLEAR) begin
            count_nxt      = '0;
            out_strobe_nxt = 1'b1;
          end else if (in_data.action == ACT_APPEND) begin
            out_strobe_nxt = 1'b1;
            priority if (count_r == CW'(DEPTH)) begin
              out_data_nxt.status = ST_FULL;
            end else if (count_r != '0 &&
                         $signed(in_data.time_s) < $signed(last_time_r)) begin
              out_data_nxt.status = ST_ORDER;
            end else begin
              we            = 1'b1;
              count_nxt     = count_r + 1'b1;
              last_time_nxt = in_data.time_s;
            end
          end else if (in_data.action == ACT_QUERY) begin
            if (count_r == '0) begin
              out_data_nxt.status = ST_NO_DATA;
              out_strobe_nxt      = 1'b1;
            end else begin
              addr_nxt  = '0;
              state_nxt = S_W0;
            end
          end else begin
            out_strobe_nxt = 1'b1;
          end
          out_data_nxt.entry_count = COUNT_OUT_W'(count_nxt);
        end
      end
      S_W0: begin
        state_nxt = S_C0;
      end
      S_C0: begin
        if ($signed(t_r) <= $signed(rdata.time_s)) begin
          out_data_nxt   = sample_word(rdata, 1'b1, count_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          addr_nxt  = last_idx;
          state_nxt = S_WL;
        end
      end
      S_WL: begin
        state_nxt = S_CL;
      end
      S_CL: begin
        if ($signed(t_r) >= $signed(rdata.time_s)) begin
          out_data_nxt   = sample_word(rdata, 1'b1, count_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_idx;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if ((hi_r - lo_r) > AW'(1)) begin
          addr_nxt  = mid;
          state_nxt = S_WM;
        end else begin
          addr_nxt  = lo_r;
          state_nxt = S_WLO;
        end
      end
      S_WM: begin
        state_nxt = S_CM;
      end
      S_CM: begin
        // Narrow the bracket around the query time
        if ($signed(rdata.time_s) <= $signed(t_r)) begin
          lo_nxt = addr_r;
        end else begin
          hi_nxt = addr_r;
        end
        state_nxt = S_SRCH;
      end
      S_WLO: begin
        addr_nxt  = hi_r;
        state_nxt = S_CLO;
      end
      S_CLO: begin
        lo_e_nxt  = rdata;
        state_nxt = S_WHI;
      end
      S_WHI: begin
        hi_e_nxt  = rdata;
        state_nxt = S_CHI;
      end
      S_CHI: begin
        // Guard a zero interval: hold the lower sample
        if ($signed(hi_e_r.time_s) <= $signed(lo_e_r.time_s)) begin
          out_data_nxt   = sample_word(lo_e_r, 1'b0, count_r);
          out_strobe_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          div_go    = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          k_nxt     = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PW'($signed({1'b0, alpha}) * dv);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        vals_nxt[k_r] = sum_s[ALPHA_BITS +: VALUE_W];
        if (k_r == 2'd3) begin
          out_data_nxt                 = '0;
          out_data_nxt.status          = ST_OK;
          out_data_nxt.flux_out        = vals_r[0];
          out_data_nxt.flux_center_out = vals_r[1];
          out_data_nxt.ap_out          = vals_r[2];
          out_data_nxt.kp_out          = sum_s[ALPHA_BITS +: VALUE_W];
          out_data_nxt.interpolated    = (alpha != '0);
          out_data_nxt.entry_count     = COUNT_OUT_W'(count_r);
          out_strobe_nxt               = 1'b1;
          state_nxt                    = S_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_MUL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    last_time_r <= last_time_nxt;
    t_r         <= t_nxt;
    addr_r      <= addr_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    lo_e_r      <= lo_e_nxt;
    hi_e_r      <= hi_e_nxt;
    k_r         <= k_nxt;
    prod_r      <= prod_nxt;
    vals_r      <= vals_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

[sv/sti_chk.sv]
// Port checker for the sorted table linear interpolator, bound to the top.
// Depends on sti_pkg for word types and codes.
module sti_chk import sti_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_word_t  in_data,
  input logic      out_strobe,
  input out_word_t out_data
);

  // Results only appear once the block is free again
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while busy");

  // Non-query words answer on the next cycle
  a_quick_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action != ACT_QUERY) |=> out_strobe)
    else $error("missing answer to clear or append");

  // A query only ends by delivering its word
  a_query_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("query finished without a result word");

  // No data only for an empty table
  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status == ST_NO_DATA) |-> out_data.entry_count == '0)
    else $error("no data with a filled table");

  // Flags exclude each other
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.interpolated) |->
      (!out_data.extrapolated && out_data.status == ST_OK))
    else $error("interpolated word with bad flags");

endmodule

bind sorted_table_linear_interpolator_top sti_chk u_sti_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

[tb/sv/sti_checker.sv]
// Result checker for the sorted table linear interpolator.
// Watches the word and result channels, keeps its own sample table and compares.
// Depends on sti_pkg.
module sti_checker import sti_pkg::*; #(
  parameter int DEPTH      = 1024,
  parameter int ALPHA_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_data,
  input  logic      out_strobe,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);

  entry_t      samples [DEPTH];
  int unsigned fill;
  out_word_t   answers [4];
  int unsigned wr_cnt;
  int unsigned rd_cnt;

  // Blend two Q12.8 values by a Q0.16 weight, truncating
  function automatic logic [VALUE_W-1:0] blend_value(logic [VALUE_W-1:0] lo_v,
                                                     logic [VALUE_W-1:0] hi_v,
                                                     longint unsigned    wgt);
    longint unsigned acc;
    acc = longint'(lo_v) * ((64'd1 << ALPHA_BITS) - wgt) + longint'(hi_v) * wgt;
    return VALUE_W'(acc >> ALPHA_BITS);
  endfunction

  // Apply one word to the local table and return the answer it should give
  function automatic out_word_t table_answer(in_word_t w);
    out_word_t       r;
    int unsigned     lo, hi, mid;
    longint          num, den;
    longint unsigned alpha;
    entry_t          a, b;
    r = '0;
    case (w.action)
      ACT_CLEAR: begin
        fill = 0;
      end
      ACT_APPEND: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else if (fill > 0 && w.time_s < samples[fill-1].time_s) begin
          r.status = ST_ORDER;
        end else begin
          samples[fill] = '{w.time_s, w.flux_in, w.flux_center_in, w.ap_in,
                            w.kp_sum_in >> KP_SHIFT};
          fill++;
        end
      end
      ACT_QUERY: begin
        if (fill == 0) begin
          r.status = ST_NO_DATA;
        end else if (w.time_s <= samples[0].time_s ||
                     w.time_s >= samples[fill-1].time_s) begin
          a = (w.time_s <= samples[0].time_s) ? samples[0] : samples[fill-1];
          {r.flux_out, r.flux_center_out, r.ap_out, r.kp_out} =
            {a.flux, a.flux_center, a.ap, a.kp};
          r.extrapolated = 1'b1;
        end else begin
          // binary search for the bracketing pair
          lo = 0;
          hi = fill - 1;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (samples[mid].time_s <= w.time_s) lo = mid;
            else hi = mid;
          end
          a = samples[lo];
          b = samples[hi];
          if (b.time_s <= a.time_s) begin
            {r.flux_out, r.flux_center_out, r.ap_out, r.kp_out} =
              {a.flux, a.flux_center, a.ap, a.kp};
          end else begin
            num   = longint'(w.time_s) - longint'(a.time_s);
            den   = longint'(b.time_s) - longint'(a.time_s);
            alpha = (longint'(num) << ALPHA_BITS) / den;
            if (alpha > (64'd1 << ALPHA_BITS)) alpha = 64'd1 << ALPHA_BITS;
            r.flux_out        = blend_value(a.flux, b.flux, alpha);
            r.flux_center_out = blend_value(a.flux_center, b.flux_center, alpha);
            r.ap_out          = blend_value(a.ap, b.ap, alpha);
            r.kp_out          = blend_value(a.kp, b.kp, alpha);
            r.interpolated    = (alpha > 0 && alpha < (64'd1 << ALPHA_BITS));
          end
        end
      end
      default: begin
      end
    endcase
    r.entry_count = fill[COUNT_OUT_W-1:0];
    return r;
  endfunction

  assign pending = int'(wr_cnt - rd_cnt);

  // Predict on each accepted word, compare each result word with the oldest answer
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      fill   = 0;
      wr_cnt = 0;
      rd_cnt = 0;
      fail_count <= 0;
    end else begin
      if (out_strobe) begin
        if (wr_cnt == rd_cnt) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected result word %h", out_data);
        end else begin
          want = answers[rd_cnt[1:0]];
          rd_cnt++;
          if (out_data !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch (got/exp): st %0d/%0d flux %h/%h fc %h/%h",
                        " ap %h/%h kp %h/%h int %b/%b ext %b/%b cnt %0d/%0d"},
                       out_data.status, want.status, out_data.flux_out, want.flux_out,
                       out_data.flux_center_out, want.flux_center_out,
                       out_data.ap_out, want.ap_out, out_data.kp_out, want.kp_out,
                       out_data.interpolated, want.interpolated,
                       out_data.extrapolated, want.extrapolated,
                       out_data.entry_count, want.entry_count);
          end
        end
      end
      if (start && !busy) begin
        answers[wr_cnt[1:0]] = table_answer(in_data);
        wr_cnt++;
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
// Testbench top for the sorted table linear interpolator.
// Drives clear, append, query and idle words and gives the verdict.
// Depends on sti_pkg, sti_checker and the block itself.
module testbench;
  import sti_pkg::*;

  localparam int         DEPTH      = 1024;
  localparam logic [1:0] ACT_IDLE   = 2'd3;
  localparam int         CYCLE_CAP  = 3000000;
  localparam longint     T_MIN      = -(64'sd1 <<< 39);
  localparam longint     T_MAX      = (64'sd1 <<< 39) - 1;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_data;
  logic      out_strobe;
  out_word_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  int        sent;
  bit        calm;

  sorted_table_linear_interpolator_top dut (.*);

  sti_checker #(.DEPTH(DEPTH)) u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    endcase
  endfunction

  // Present one word and hold it until taken
  task automatic send_word(logic [1:0] act, longint t);
    in_word_t w;
    w.action         = act;
    w.time_s         = t[TIME_W-1:0];
    w.flux_in        = rand_value();
    w.flux_center_in = rand_value();
    w.ap_in          = rand_value();
    w.kp_sum_in      = rand_value();
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
    if (!calm && $urandom_range(0, 99) < 38) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Hold off until every answer is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic longint rand_time();
    longint t;
    t = {$urandom, $urandom};
    return t[39] ? (t | ~((64'sd1 <<< 40) - 1)) : (t & ((64'sd1 <<< 40) - 1));
  endfunction

  initial begin
    longint base, t, span;
    int     n;
    sent    = 0;
    calm    = 1'b0;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: ends of the time range, extrapolation, tiny fraction, refusals
    send_word(ACT_QUERY, 0);
    send_word(ACT_APPEND, T_MIN);
    send_word(ACT_APPEND, T_MIN);
    send_word(ACT_QUERY, T_MIN);
    send_word(ACT_APPEND, T_MAX);
    send_word(ACT_QUERY, T_MIN + 1);
    send_word(ACT_QUERY, 0);
    send_word(ACT_QUERY, T_MAX - 1);
    send_word(ACT_QUERY, T_MAX);
    send_word(ACT_APPEND, 0);
    send_word(ACT_IDLE, T_MAX);
    send_word(ACT_CLEAR, 0);
    send_word(ACT_QUERY, -1);
    send_word(ACT_APPEND, 100);
    send_word(ACT_APPEND, 300);
    send_word(ACT_QUERY, 200);
    send_word(ACT_QUERY, 299);
    send_word(ACT_QUERY, 101);
    drain();

    // Fill the table to the brim, then refuse two more
    send_word(ACT_CLEAR, 0);
    calm = 1'b1;
    for (int i = 0; i < DEPTH; i++) send_word(ACT_APPEND, longint'(i) * 1000 - 7);
    send_word(ACT_APPEND, T_MAX);
    send_word(ACT_APPEND, 0);
    calm = 1'b0;
    for (int i = 0; i < 8; i++) send_word(ACT_QUERY, $urandom_range(0, DEPTH * 1000));
    send_word(ACT_CLEAR, 0);
    drain();

    // Random: well-formed tables with random content, plus noise
    sent = 0;
    while (sent < 750) begin
      calm = (sent > 300 && sent < 420);
      if ($urandom_range(0, 9) == 0) begin
        send_word(2'($urandom_range(0, 3)), rand_time());
      end else begin
        send_word(ACT_CLEAR, rand_time());
        n    = $urandom_range(1, 30);
        base = $urandom_range(0, 1) ? rand_time() >>> 1 : longint'($urandom_range(0, 1000)) - 500;
        t    = base;
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 7))
            0:       t = t;
            1:       t = t + $urandom_range(1, 3);
            2:       t = t + $urandom_range(0, 1 << 20);
            default: t = t + $urandom_range(1, 5000);
          endcase
          send_word(ACT_APPEND, t);
          if ($urandom_range(0, 15) == 0) send_word(ACT_APPEND, t - $urandom_range(1, 50));
        end
        span = t - base;
        repeat ($urandom_range(2, 12)) begin
          if ($urandom_range(0, 9) == 0)
            send_word(ACT_QUERY, rand_time());
          else
            send_word(ACT_QUERY, base - 3 + longint'($urandom_range(0, 32'(span + 6))));
        end
      end
      if ($urandom_range(0, 199) == 0) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

[sorted_table_linear_interpolator_top.f]
sv/sti_pkg.sv
sv/sti_mem.sv
sv/sti_div.sv
sv/sorted_table_linear_interpolator_top.sv
sv/sti_chk.sv
tb/sv/sti_checker.sv
tb/sv/testbench.sv
